[design/dra_pkg.sv]
// ----------------------------------------------------------------------------
// Descriptor run allocator package
// Field widths, status codes and register indices.
// ----------------------------------------------------------------------------
package dra_pkg;

	localparam int IDX_W   = 10;
	localparam int NUM_IDX = 1024;
	localparam int CNT_W   = 11;
	localparam int ADDR_W  = 48;
	localparam int STR_W   = 13;
	localparam int OFF_W   = IDX_W + STR_W;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_TOO_FEW  = 3'd1;
	localparam status_t ST_NO_RUN   = 3'd2;
	localparam status_t ST_ZERO     = 3'd3;
	localparam status_t ST_OVERFLOW = 3'd4;

	typedef logic [2:0] reg_idx_t;

	localparam reg_idx_t REG_CAPACITY = 3'd0;
	localparam reg_idx_t REG_STRIDE   = 3'd1;
	localparam reg_idx_t REG_CPU_BASE = 3'd2;
	localparam reg_idx_t REG_GPU_BASE = 3'd3;
	localparam reg_idx_t REG_VISIBLE  = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

endpackage

[design/descriptor_run_allocator.sv]
// Multi-slot alloc builds a histogram, then makes a sorted emit pass.
// One item at a time; the next is taken once the result sits in the output register.
// Reset: a sweep fills the stack and clears the histogram.
// A capacity write refills the stack with min(capacity, MAX_SLOTS) slots; no items meanwhile.
// Register writes are taken only while idle, and win over an input offered in the same cycle.
// ----------------------------------------------------------------------------
// Descriptor run allocator
// Free stack of slot indices with contiguous run allocation by counting sort.
// ----------------------------------------------------------------------------
module descriptor_run_allocator import dra_pkg::*; #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [CNT_W-1:0]  count,
	input  logic [IDX_W-1:0]  first_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [IDX_W-1:0]  slot_index,
	output logic [ADDR_W-1:0] cpu_address,
	output logic [ADDR_W-1:0] gpu_address,
	output logic [CNT_W-1:0]  free_count,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [ADDR_W-1:0] cfg_data
);

	localparam int SPAN  = (MAX_SLOTS > NUM_IDX) ? MAX_SLOTS : NUM_IDX;
	localparam int CW    = $clog2(SPAN + 2049);
	localparam int AW    = $clog2(MAX_SLOTS);
	localparam int RST_N = (MAX_SLOTS < NUM_IDX) ? MAX_SLOTS : NUM_IDX;

	localparam logic [3:0] S_INIT   = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_PUSH   = 4'd2;
	localparam logic [3:0] S_POP_RD = 4'd3;
	localparam logic [3:0] S_POP_WT = 4'd4;
	localparam logic [3:0] S_H_RD   = 4'd5;
	localparam logic [3:0] S_H_WT   = 4'd6;
	localparam logic [3:0] S_H_WR   = 4'd7;
	localparam logic [3:0] S_E_RD   = 4'd8;
	localparam logic [3:0] S_E_WT   = 4'd9;
	localparam logic [3:0] S_E_EMIT = 4'd10;
	localparam logic [3:0] S_MUL    = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	logic [IDX_W-1:0] stack_mem [MAX_SLOTS];
	logic [CW-1:0]    hist_mem  [NUM_IDX];

	logic [3:0]        state_q;
	logic [STR_W-1:0]  stride_q;
	logic [ADDR_W-1:0] cpu_base_q, gpu_base_q;
	logic              vis_q;
	logic [CW-1:0]     len_q, n_q, sw_q, i_q, cnt_q, p_q, run_q, ucount_q;
	logic              clr_hist_q, found_q, got_q;
	logic [IDX_W-1:0]  first_q, v_q, prev_q, hv_q, slot_q;
	status_t           st_q;
	logic [OFF_W-1:0]  off_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [IDX_W-1:0]  slot_out_q;
	logic [ADDR_W-1:0] cpu_q, gpu_q;
	logic [CNT_W-1:0]  free_q;

	logic [IDX_W-1:0]  stack_rd_q;
	logic [CW-1:0]     hist_rd_q;

	logic              stk_we, hist_we;
	logic [AW-1:0]     stk_wa, stk_ra;
	logic [IDX_W-1:0]  stk_wd, hist_wa, hist_ra;
	logic [CW-1:0]     hist_wd, cap_n, emit_pos, run_nx, cfg_cap_n;
	logic              in_acc, cfg_acc, sweep_done, fin_load;

	assign in_acc  = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE);

	assign cfg_cap_n = (CW'(cfg_data[CNT_W-1:0]) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS)
	                   : CW'(cfg_data[CNT_W-1:0]);
	assign cap_n = n_q;
	assign sweep_done = (sw_q >= cap_n) && (!clr_hist_q || sw_q >= CW'(NUM_IDX));

	assign emit_pos = found_q ? (p_q - ucount_q) : p_q;
	assign run_nx = (p_q != '0 && {1'b0, v_q} == {1'b0, prev_q} + 11'd1) ? run_q + 1'b1
	                : CW'(1);
	assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// memory port control
	always_comb begin
		stk_we  = 1'b0;
		stk_wa  = '0;
		stk_wd  = '0;
		stk_ra  = '0;
		hist_we = 1'b0;
		hist_wa = '0;
		hist_wd = '0;
		hist_ra = '0;
		unique case (state_q)
			S_INIT: begin
				stk_we  = (sw_q < cap_n);
				stk_wa  = sw_q[AW-1:0];
				stk_wd  = sw_q[IDX_W-1:0];
				hist_we = clr_hist_q && (sw_q < CW'(NUM_IDX));
				hist_wa = sw_q[IDX_W-1:0];
			end
			S_PUSH: begin
				stk_we = 1'b1;
				stk_wa = len_q[AW-1:0];
				stk_wd = first_q + i_q[IDX_W-1:0];
			end
			S_POP_RD: stk_ra = len_q[AW-1:0] - 1'b1;
			S_H_RD:   stk_ra = i_q[AW-1:0];
			S_H_WT:   hist_ra = stack_rd_q;
			S_H_WR: begin
				hist_we = 1'b1;
				hist_wa = hv_q;
				hist_wd = hist_rd_q + 1'b1;
			end
			S_E_RD:   hist_ra = v_q;
			S_E_WT: begin
				hist_we = 1'b1;
				hist_wa = v_q;
			end
			S_E_EMIT: begin
				stk_we = (cnt_q != '0);
				stk_wa = emit_pos[AW-1:0];
				stk_wd = v_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_wa] <= stk_wd;
		end
		stack_rd_q <= stack_mem[stk_ra];
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		hist_rd_q <= hist_mem[hist_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			off_q <= slot_q * stride_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			stride_q   <= STR_W'(32);
			cpu_base_q <= '0;
			gpu_base_q <= '0;
			vis_q      <= 1'b1;
			len_q      <= CW'(RST_N);
			n_q        <= CW'(RST_N);
			sw_q       <= '0;
			clr_hist_q <= 1'b1;
			i_q        <= '0;
			cnt_q      <= '0;
			p_q        <= '0;
			run_q      <= '0;
			ucount_q   <= '0;
			found_q    <= 1'b0;
			got_q      <= 1'b0;
			first_q    <= '0;
			v_q        <= '0;
			prev_q     <= '0;
			hv_q       <= '0;
			slot_q     <= '0;
			st_q       <= ST_OK;
		end else begin
			unique case (state_q)
				S_INIT: begin
					sw_q <= sw_q + 1'b1;
					if (sweep_done) begin
						state_q    <= S_IDLE;
						clr_hist_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						ucount_q <= CW'(count);
						first_q  <= first_index;
						i_q      <= '0;
						slot_q   <= '0;
						got_q    <= 1'b0;
						st_q     <= ST_OK;
						if (count == '0) begin
							st_q    <= ST_ZERO;
							state_q <= S_MUL;
						end else if (func == FUNC_FREE) begin
							if (len_q + CW'(count) > CW'(MAX_SLOTS)) begin
								st_q    <= ST_OVERFLOW;
								state_q <= S_MUL;
							end else begin
								state_q <= S_PUSH;
							end
						end else if (CW'(count) > len_q) begin
							st_q    <= ST_TOO_FEW;
							state_q <= S_MUL;
						end else if (count == CNT_W'(1)) begin
							state_q <= S_POP_RD;
						end else begin
							state_q <= S_H_RD;
						end
					end
				end
				S_PUSH: begin
					len_q <= len_q + 1'b1;
					i_q   <= i_q + 1'b1;
					if (i_q == ucount_q - 1'b1) begin
						state_q <= S_MUL;
					end
				end
				S_POP_RD: begin
					len_q   <= len_q - 1'b1;
					state_q <= S_POP_WT;
				end
				S_POP_WT: begin
					slot_q  <= stack_rd_q;
					got_q   <= 1'b1;
					state_q <= S_MUL;
				end
				S_H_RD: begin
					if (i_q == len_q) begin
						v_q     <= '0;
						p_q     <= '0;
						run_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_E_RD;
					end else begin
						state_q <= S_H_WT;
					end
				end
				S_H_WT: begin
					hv_q    <= stack_rd_q;
					state_q <= S_H_WR;
				end
				S_H_WR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_H_RD;
				end
				S_E_RD: state_q <= S_E_WT;
				S_E_WT: begin
					cnt_q   <= hist_rd_q;
					state_q <= S_E_EMIT;
				end
				S_E_EMIT: begin
					if (cnt_q == '0) begin
						if (v_q == IDX_W'(NUM_IDX - 1)) begin
							if (found_q) begin
								len_q <= len_q - ucount_q;
								got_q <= 1'b1;
							end else begin
								st_q <= ST_NO_RUN;
							end
							state_q <= S_MUL;
						end else begin
							v_q     <= v_q + 1'b1;
							state_q <= S_E_RD;
						end
					end else begin
						cnt_q  <= cnt_q - 1'b1;
						p_q    <= p_q + 1'b1;
						prev_q <= v_q;
						run_q  <= run_nx;
						// first run that reaches the request wins
						if (!found_q && run_nx == ucount_q) begin
							found_q <= 1'b1;
							slot_q  <= v_q - ucount_q[IDX_W-1:0] + 1'b1;
						end
					end
				end
				S_MUL: state_q <= S_FIN;
				S_FIN: begin
					if (fin_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (cfg_acc) begin
				case (cfg_index)
					REG_CAPACITY: begin
						n_q     <= cfg_cap_n;
						len_q   <= cfg_cap_n;
						sw_q    <= '0;
						state_q <= S_INIT;
					end
					REG_STRIDE:   stride_q   <= cfg_data[STR_W-1:0];
					REG_CPU_BASE: cpu_base_q <= cfg_data;
					REG_GPU_BASE: gpu_base_q <= cfg_data;
					REG_VISIBLE:  vis_q      <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			status_q   <= st_q;
			slot_out_q <= got_q ? slot_q : '0;
			cpu_q      <= (got_q && cpu_base_q != '0) ? cpu_base_q + ADDR_W'(off_q) : '0;
			gpu_q      <= (got_q && vis_q && gpu_base_q != '0) ?
			              gpu_base_q + ADDR_W'(off_q) : '0;
			free_q     <= len_q[CNT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_index  = slot_out_q;
	assign cpu_address = cpu_q;
	assign gpu_address = gpu_q;
	assign free_count  = free_q;

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CW'(MAX_SLOTS))
		else $error("free stack length beyond depth");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE)
		else $error("input taken outside idle");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish");

	a_err_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_OK |-> slot_out_q == '0 && cpu_q == '0)
		else $error("failed request carries an address");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_E_EMIT && found_q |-> p_q >= ucount_q)
		else $error("run found before enough slots emitted");

endmodule

[dv/descriptor_run_allocator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor run allocator testbench
// Drives alloc and free requests and register writes under random gaps and
// back-pressure. A behavioural model of the free stack predicts each result,
// and the scoreboard compares every output field in order.
// ----------------------------------------------------------------------------
module descriptor_run_allocator_test;
	import dra_pkg::*;

	typedef struct {
		status_t            st;
		logic [IDX_W-1:0]   slot;
		logic [ADDR_W-1:0]  cpu;
		logic [ADDR_W-1:0]  gpu;
		logic [CNT_W-1:0]   nfree;
	} alloc_result_t;

	class alloc_scoreboard;
		logic [IDX_W-1:0]  stk[NUM_IDX];
		int                len;
		int unsigned       capacity_r;
		logic [STR_W-1:0]  stride_r;
		logic [ADDR_W-1:0] cpu_base_r;
		logic [ADDR_W-1:0] gpu_base_r;
		logic              visible_r;
		alloc_result_t     pending_q[$];
		int                errors;

		function void refill();
			int n;
			n = (capacity_r > NUM_IDX) ? NUM_IDX : capacity_r;
			for (int i = 0; i < n; i++)
				stk[i] = i[IDX_W-1:0];
			len = n;
		endfunction

		function void reset_state();
			capacity_r = 1024; stride_r = 32; cpu_base_r = 0; gpu_base_r = 0;
			visible_r = 1; errors = 0;
			refill();
		endfunction

		function void write_reg(reg_idx_t idx, logic [ADDR_W-1:0] d);
			case (idx)
				REG_CAPACITY: begin capacity_r = d[CNT_W-1:0]; refill(); end
				REG_STRIDE:   stride_r = d[STR_W-1:0];
				REG_CPU_BASE: cpu_base_r = d;
				REG_GPU_BASE: gpu_base_r = d;
				REG_VISIBLE:  visible_r = d[0];
				default: ;
			endcase
		endfunction

		// predict the result of one accepted request
		function void note_request(logic f, logic [CNT_W-1:0] cnt, logic [IDX_W-1:0] first);
			alloc_result_t r;
			logic got;
			int run, start, j;
			logic [IDX_W-1:0] v;
			logic [ADDR_W-1:0] off;
			r.st = ST_OK; r.slot = 0; r.cpu = 0; r.gpu = 0; got = 0;
			if (cnt == 0) r.st = ST_ZERO;
			else if (f == FUNC_FREE) begin
				if (len + cnt > NUM_IDX) r.st = ST_OVERFLOW;
				else begin
					for (int i = 0; i < cnt; i++)
						stk[len + i] = first + i[IDX_W-1:0];
					len = len + cnt;
				end
			end else if (cnt > len) r.st = ST_TOO_FEW;
			else if (cnt == 1) begin
				len = len - 1;
				r.slot = stk[len]; got = 1;
			end else begin
				// ascending insertion sort
				for (int i = 1; i < len; i++) begin
					v = stk[i];
					j = i;
					while (j > 0 && stk[j-1] > v) begin
						stk[j] = stk[j-1];
						j--;
					end
					stk[j] = v;
				end
				r.st = ST_NO_RUN; run = 1;
				for (int k = 1; k < len; k++) begin
					run = (stk[k] - stk[k-1] == 1) ? run + 1 : 1;
					if (run == cnt) begin
						start = k + 1 - cnt;
						r.slot = stk[start];
						for (int m = start; m < len - cnt; m++) stk[m] = stk[m + cnt];
						len = len - cnt;
						r.st = ST_OK; got = 1;
						break;
					end
				end
			end
			if (got) begin
				off = r.slot * stride_r;
				if (cpu_base_r != 0) r.cpu = cpu_base_r + off;
				if (visible_r && gpu_base_r != 0) r.gpu = gpu_base_r + off;
			end
			r.nfree = CNT_W'(len);
			pending_q.insert(pending_q.size(), r);
		endfunction

		function void check_result(alloc_result_t a);
			alloc_result_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected result transfer"); errors++; return;
			end
			e = pending_q.pop_front();
			if (a.st !== e.st) begin
				$error("status exp %0d got %0d", e.st, a.st); errors++; end
			if (a.slot !== e.slot) begin
				$error("slot_index exp %0d got %0d", e.slot, a.slot); errors++; end
			if (a.cpu !== e.cpu) begin
				$error("cpu_address exp %h got %h", e.cpu, a.cpu); errors++; end
			if (a.gpu !== e.gpu) begin
				$error("gpu_address exp %h got %h", e.gpu, a.gpu); errors++; end
			if (a.nfree !== e.nfree) begin
				$error("free_count exp %0d got %0d", e.nfree, a.nfree); errors++; end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, func = 0;
	logic [CNT_W-1:0] count = 0;
	logic [IDX_W-1:0] first_index = 0;
	logic out_valid, out_ready = 0;
	logic [2:0] status;
	logic [IDX_W-1:0] slot_index;
	logic [ADDR_W-1:0] cpu_address, gpu_address;
	logic [CNT_W-1:0] free_count;
	logic cfg_valid = 0, cfg_ready;
	logic [2:0] cfg_index = 0;
	logic [ADDR_W-1:0] cfg_data = 0;
	logic hold_off = 0;

	alloc_scoreboard sb = new();

	descriptor_run_allocator dut (.*);

	always #1 clk = ~clk;

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
	endfunction

	// returns at the accepting edge; valid stays up unless a gap follows
	task automatic send_request(logic f, logic [CNT_W-1:0] cnt, logic [IDX_W-1:0] first,
			bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		@(negedge clk);
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
		func <= f; count <= cnt; first_index <= first; in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(f, cnt, first);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [ADDR_W-1:0] d);
		@(negedge clk);
		in_valid <= 0;
		// wait for the block to drain, then let it settle
		wait (sb.pending_q.size() == 0);
		repeat (3500) @(negedge clk);
		cfg_index <= idx; cfg_data <= d; cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic random_phase(int n, int max_cnt);
		int c;
		for (int i = 0; i < n; i++) begin
			c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, max_cnt) : $urandom_range(0, 8);
			send_request(1'($urandom_range(0, 1)), CNT_W'(c),
				IDX_W'($urandom_range(0, NUM_IDX - 1)), 1);
		end
	endtask

	// result side
	always @(posedge clk) begin
		alloc_result_t a;
		if (out_valid && out_ready) begin
			a.st = status; a.slot = slot_index; a.cpu = cpu_address;
			a.gpu = gpu_address; a.nfree = free_count;
			sb.check_result(a);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_off) out_ready <= 0;
			else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 0;
				repeat (gap_len()) @(negedge clk);
			end else out_ready <= 1;
		end
	end

	initial begin
		#25000000;
		$display("descriptor_run_allocator_test: errors");
		$finish;
	end

	initial begin
		sb.reset_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// directed: defaults, then extremes and error cases
		send_request(FUNC_ALLOC, 0, 0, 0);
		send_request(FUNC_FREE, 0, 5, 0);
		send_request(FUNC_ALLOC, 1, 0, 0);
		send_request(FUNC_ALLOC, 1025, 0, 0);
		send_request(FUNC_FREE, 2, 0, 0);
		send_request(FUNC_ALLOC, 4, 0, 0);
		send_request(FUNC_ALLOC, 1023, 0, 0);
		send_request(FUNC_FREE, 1024, 1023, 0);
		send_request(FUNC_ALLOC, 1020, 0, 0);
		write_reg(REG_STRIDE, 4096);
		write_reg(REG_CPU_BASE, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_GPU_BASE, 48'hFFFF_FFFF_F000);
		write_reg(REG_CAPACITY, 16);
		send_request(FUNC_ALLOC, 1, 0, 0);
		send_request(FUNC_ALLOC, 15, 0, 0);
		send_request(FUNC_FREE, 3, 1022, 0);
		send_request(FUNC_FREE, 2, 1022, 0);
		send_request(FUNC_ALLOC, 2, 0, 0);
		send_request(FUNC_ALLOC, 3, 0, 0);
		send_request(FUNC_FREE, 1009, 7, 0);
		send_request(FUNC_FREE, 1, 7, 0);
		write_reg(REG_VISIBLE, 0);
		write_reg(REG_STRIDE, 0);
		write_reg(REG_CAPACITY, 0);
		send_request(FUNC_ALLOC, 1, 0, 0);
		send_request(FUNC_FREE, 4, 100, 0);
		send_request(FUNC_ALLOC, 4, 0, 0);
		write_reg(REG_CAPACITY, 2047);
		send_request(FUNC_ALLOC, 1024, 0, 0);
		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_off = 1;
				repeat (400) @(negedge clk);
				hold_off = 0;
			end
			random_phase(10, 8);
		join
		random_phase(60, 1024);
		write_reg(REG_CAPACITY, 40);
		write_reg(REG_STRIDE, ADDR_W'($urandom_range(1, 4096)));
		write_reg(REG_CPU_BASE, ADDR_W'({$urandom, $urandom}));
		write_reg(REG_GPU_BASE, ADDR_W'({$urandom, $urandom}));
		write_reg(REG_VISIBLE, 1);
		random_phase(80, 64);
		write_reg(REG_CAPACITY, 1);
		random_phase(40, 4);
		write_reg(REG_CAPACITY, 200);
		write_reg(REG_STRIDE, 1);
		random_phase(80, 260);
		@(negedge clk);
		in_valid <= 0;
		wait (sb.pending_q.size() == 0);
		repeat (3500) @(negedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("descriptor_run_allocator_test: clean");
		else
			$display("descriptor_run_allocator_test: errors");
		$finish;
	end
endmodule
